// ===== src/bcs_pkg.sv =====
// Shared types and constants for the I2C bus-clear sequencer.
`default_nettype none

package bcs_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SCL_WAIT    = 2'd1;
    localparam logic [1:0] CFG_MAX_PULSES  = 2'd2;

    // Register reset values.
    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd5;
    localparam logic [15:0] SCL_WAIT_RESET    = 16'd500;
    localparam logic [3:0]  MAX_PULSES_RESET  = 4'd9;

    // Final result codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_LINE_LOW = 2'd2;

    // Sequencer phases, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_SETTLE = 11'b000_0000_0010,
        PH_WAIT   = 11'b000_0000_0100,
        PH_PLOW   = 11'b000_0000_1000,
        PH_PWAIT  = 11'b000_0001_0000,
        PH_PHIGH  = 11'b000_0010_0000,
        PH_SCLLOW = 11'b000_0100_0000,
        PH_SDALOW = 11'b000_1000_0000,
        PH_SWAIT  = 11'b001_0000_0000,
        PH_SHOLD  = 11'b010_0000_0000,
        PH_SEND   = 11'b100_0000_0000
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  half_period_ticks;
        logic [15:0] scl_wait_limit;
        logic [3:0]  max_pulses;
    } cfg_t;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] tick_count;
        logic [3:0]  pulse_count;
        logic [1:0]  last_status;
    } seq_state_t;

    // One input tick.
    typedef struct packed {
        logic sda_level;
        logic scl_level;
        logic start_request;
    } tick_in_t;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } tick_out_t;

endpackage

`default_nettype wire

// ===== src/i2c_bus_clear_sequencer.sv =====
// Top level of the I2C bus-clear sequencer: input register, state, result register.
//
//   Channel   Direction  Signals                          Contents
//   s_        in         s_tvalid s_tready s_tdata[7:0]   one tick of sampled lines
//   m_        out        m_tvalid m_tready m_tdata[7:0]   line drives and status
//   cfg_      in         cfg_valid cfg_ready cfg_index    register writes
//                        cfg_data[15:0]
//
// Each tick is registered on input, advanced through the sequencer by the
// combinational step logic and lands in the result register; one tick per cycle
// is sustained while m_tready stays high. The single-step state update sets that rate.
// Reset returns the sequencer to idle with status ok and default registers.
// A stalled result register holds the pending tick in the input register.
`default_nettype none

module i2c_bus_clear_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] start_request, [1] scl_level, [2] sda_level
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] scl_pull_low, [1] sda_pull_low,
                                        // [2] busy_res, [3] done_res, [5:4] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bcs_pkg::cfg_t       cfg;
    bcs_pkg::tick_in_t   in_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    bcs_pkg::seq_state_t state_reg;
    bcs_pkg::seq_state_t state_next;
    bcs_pkg::tick_out_t  step_out;
    bcs_pkg::tick_out_t  out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                advance;
    logic                s_xfer;

    bcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .tin  (in_reg),
        .nxt  (state_next),
        .tout (step_out)
    );

    // A tick advances when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= bcs_pkg::PH_IDLE;
            state_reg.tick_count  <= 16'd0;
            state_reg.pulse_count <= 4'd0;
            state_reg.last_status <= bcs_pkg::STATUS_OK;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg.start_request <= s_tdata[0];
            in_reg.scl_level     <= s_tdata[1];
            in_reg.sda_level     <= s_tdata[2];
        end
        if (advance) begin
            out_reg <= step_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.done_res, out_reg.busy_res,
                       out_reg.sda_pull_low, out_reg.scl_pull_low};

endmodule

`default_nettype wire

// ===== src/bcs_cfg.sv =====
// Configuration register file of the bus-clear sequencer.
`default_nettype none

module bcs_cfg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output bcs_pkg::cfg_t     cfg
);

    bcs_pkg::cfg_t cfg_reg;
    bcs_pkg::cfg_t cfg_next;

    // Writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bcs_pkg::CFG_HALF_PERIOD: cfg_next.half_period_ticks = cfg_data[7:0];
                bcs_pkg::CFG_SCL_WAIT:    cfg_next.scl_wait_limit    = cfg_data;
                bcs_pkg::CFG_MAX_PULSES:  cfg_next.max_pulses        = cfg_data[3:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= bcs_pkg::HALF_PERIOD_RESET;
            cfg_reg.scl_wait_limit    <= bcs_pkg::SCL_WAIT_RESET;
            cfg_reg.max_pulses        <= bcs_pkg::MAX_PULSES_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bcs_step.sv =====
// Next-state and output logic for one tick of the bus-clear sequencer.
`default_nettype none

module bcs_step (
    input  wire bcs_pkg::cfg_t        cfg,
    input  wire bcs_pkg::seq_state_t  cur,
    input  wire bcs_pkg::tick_in_t    tin,
    output bcs_pkg::seq_state_t       nxt,
    output bcs_pkg::tick_out_t        tout
);

    logic [7:0]  half_eff;
    logic [15:0] tick_inc;
    logic        delay_done;
    logic        wait_high;
    logic        wait_timeout;
    logic [15:0] wait_tick;
    logic [3:0]  pulse_inc;
    logic        done;

    // Shared delay and SCL-wait helpers; a zero half period counts as one.
    always_comb begin
        half_eff     = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
        tick_inc     = cur.tick_count + 16'd1;
        delay_done   = (tick_inc >= {8'd0, half_eff});
        wait_high    = tin.scl_level;
        wait_timeout = !tin.scl_level && (cur.tick_count >= cfg.scl_wait_limit);
        wait_tick    = (wait_high || wait_timeout) ? 16'd0 : tick_inc;
        pulse_inc    = cur.pulse_count + 4'd1;
    end

    // Phase transitions.
    always_comb begin
        nxt  = cur;
        done = 1'b0;
        case (cur.phase)
            bcs_pkg::PH_IDLE: begin
                if (tin.start_request) begin
                    nxt.phase      = bcs_pkg::PH_SETTLE;
                    nxt.tick_count = 16'd0;
                end
            end
            bcs_pkg::PH_SETTLE, bcs_pkg::PH_PLOW, bcs_pkg::PH_SCLLOW,
            bcs_pkg::PH_SDALOW, bcs_pkg::PH_SHOLD: begin
                nxt.tick_count = delay_done ? 16'd0 : tick_inc;
                if (delay_done) begin
                    case (cur.phase)
                        bcs_pkg::PH_SETTLE: nxt.phase = bcs_pkg::PH_WAIT;
                        bcs_pkg::PH_PLOW:   nxt.phase = bcs_pkg::PH_PWAIT;
                        bcs_pkg::PH_SCLLOW: nxt.phase = bcs_pkg::PH_SDALOW;
                        bcs_pkg::PH_SDALOW: nxt.phase = bcs_pkg::PH_SWAIT;
                        default:            nxt.phase = bcs_pkg::PH_SEND;
                    endcase
                end
            end
            bcs_pkg::PH_WAIT: begin
                nxt.tick_count = wait_tick;
                if (wait_high) begin
                    if (!tin.sda_level) begin
                        nxt.pulse_count = 4'd0;
                        nxt.phase = (cfg.max_pulses == 4'd0) ? bcs_pkg::PH_SCLLOW
                                                              : bcs_pkg::PH_PLOW;
                    end else begin
                        nxt.phase = bcs_pkg::PH_SCLLOW;
                    end
                end else if (wait_timeout) begin
                    nxt.phase       = bcs_pkg::PH_IDLE;
                    nxt.last_status = bcs_pkg::STATUS_TIMEOUT;
                    done            = 1'b1;
                end
            end
            bcs_pkg::PH_PWAIT: begin
                nxt.tick_count = wait_tick;
                if (wait_high) begin
                    nxt.phase = bcs_pkg::PH_PHIGH;
                end else if (wait_timeout) begin
                    nxt.phase       = bcs_pkg::PH_IDLE;
                    nxt.last_status = bcs_pkg::STATUS_TIMEOUT;
                    done            = 1'b1;
                end
            end
            bcs_pkg::PH_PHIGH: begin
                nxt.tick_count = delay_done ? 16'd0 : tick_inc;
                if (delay_done) begin
                    nxt.pulse_count = pulse_inc;
                    nxt.phase = (tin.sda_level || (pulse_inc >= cfg.max_pulses))
                              ? bcs_pkg::PH_SCLLOW : bcs_pkg::PH_PLOW;
                end
            end
            bcs_pkg::PH_SWAIT: begin
                // A time-out during the stop condition is not reported.
                nxt.tick_count = wait_tick;
                if (wait_high || wait_timeout) begin
                    nxt.phase = bcs_pkg::PH_SHOLD;
                end
            end
            bcs_pkg::PH_SEND: begin
                nxt.tick_count = delay_done ? 16'd0 : tick_inc;
                if (delay_done) begin
                    nxt.phase       = bcs_pkg::PH_IDLE;
                    nxt.last_status = (tin.scl_level && tin.sda_level)
                                    ? bcs_pkg::STATUS_OK : bcs_pkg::STATUS_LINE_LOW;
                    done            = 1'b1;
                end
            end
            default: begin
                nxt.phase      = bcs_pkg::PH_IDLE;
                nxt.tick_count = 16'd0;
            end
        endcase
    end

    // Line drives and flags follow the phase after this tick.
    always_comb begin
        tout.scl_pull_low = (nxt.phase == bcs_pkg::PH_PLOW)   ||
                            (nxt.phase == bcs_pkg::PH_SCLLOW) ||
                            (nxt.phase == bcs_pkg::PH_SDALOW);
        tout.sda_pull_low = (nxt.phase == bcs_pkg::PH_SDALOW) ||
                            (nxt.phase == bcs_pkg::PH_SWAIT)  ||
                            (nxt.phase == bcs_pkg::PH_SHOLD);
        tout.busy_res     = (nxt.phase != bcs_pkg::PH_IDLE);
        tout.done_res     = done;
        tout.status       = nxt.last_status;
    end

endmodule

`default_nettype wire

// ===== tb/sv/i2c_bus_clear_sequencer_tb.sv =====
// Self-checking testbench for the I2C bus-clear sequencer: directed ticks, then biased random.
`timescale 1ns / 100ps

module i2c_bus_clear_sequencer_tb;

    // Outcome of one SCL poll while the sequencer waits for the line to rise.
    typedef enum int {SCL_PENDING, SCL_HIGH, SCL_TIMED_OUT} scl_poll_e;

    // Kind of a row in the directed table.
    typedef enum int {ROW_TICK, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e           kind;
        logic [1:0]          reg_idx;
        logic [15:0]         reg_val;
        logic                start;
        logic                scl;
        logic                sda;
        bit                  typed;
        bcs_pkg::tick_out_t  want;
    } dir_row_t;

    localparam bcs_pkg::tick_out_t QUIET_IDLE    = '0;
    localparam bcs_pkg::tick_out_t DONE_TIMEOUT  =
        '{status: bcs_pkg::STATUS_TIMEOUT, done_res: 1'b1, default: 1'b0};
    localparam bcs_pkg::tick_out_t DONE_LINE_LOW =
        '{status: bcs_pkg::STATUS_LINE_LOW, done_res: 1'b1, default: 1'b0};
    localparam bcs_pkg::tick_out_t DONE_CLEAN    =
        '{status: bcs_pkg::STATUS_OK, done_res: 1'b1, default: 1'b0};

    localparam int DIR_ROWS      = 29;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_TICKS   = 210;
    localparam int EPISODE_TICKS = 60;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;

    // Directed sequence. Register columns are unused on tick rows.
    // First a timeout in the opening wait, then a stuck SDA with start requests while
    // busy and a timed-out wait inside the stop condition, then no pulses at all.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, QUIET_IDLE},
        '{ROW_WRITE, bcs_pkg::CFG_HALF_PERIOD, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_WRITE, bcs_pkg::CFG_SCL_WAIT,    16'd1, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_WRITE, bcs_pkg::CFG_MAX_PULSES,  16'd1, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, DONE_TIMEOUT},
        '{ROW_TICK,  '0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1, DONE_LINE_LOW},
        '{ROW_WRITE, bcs_pkg::CFG_MAX_PULSES,  16'd0, 1'b0, 1'b0, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, QUIET_IDLE},
        '{ROW_TICK,  '0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, DONE_CLEAN}
    };

    // Line biases in percent, picked per episode of random ticks.
    int start_bias [3] = '{1, 5, 30};
    int scl_bias   [4] = '{97, 85, 50, 3};
    int sda_bias   [4] = '{97, 60, 15, 0};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predicted sequencer state and its register copy.
    bcs_pkg::phase_t seq_phase;
    logic [15:0]     seq_ticks;
    logic [3:0]      pulses_given;
    logic [1:0]      last_result;
    logic [7:0]      half_period_cfg;
    logic [15:0]     wait_limit_cfg;
    logic [3:0]      max_pulses_cfg;

    bcs_pkg::tick_out_t pending_drive_q [$];
    int                 error_count = 0;
    bit                 quiet_mode  = 1'b0;

    i2c_bus_clear_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gap before the next transfer on either side; none at all in quiet stretches.
    function automatic int draw_gap();
        if (quiet_mode) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic void enter_phase(input bcs_pkg::phase_t next);
        seq_phase = next;
        seq_ticks = '0;
    endfunction

    // One tick of a timed half-period delay; a zero half period counts as one tick.
    function automatic bit half_period_elapsed();
        logic [15:0] span;
        span = (half_period_cfg == 8'd0) ? 16'd1 : {8'd0, half_period_cfg};
        seq_ticks = seq_ticks + 16'd1;
        if (seq_ticks >= span) begin
            seq_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // SCL is checked on every tick of a wait, the first one included.
    function automatic scl_poll_e poll_scl_rise(input logic scl);
        if (scl) begin
            seq_ticks = '0;
            return SCL_HIGH;
        end
        if (seq_ticks >= wait_limit_cfg) begin
            seq_ticks = '0;
            return SCL_TIMED_OUT;
        end
        seq_ticks = seq_ticks + 16'd1;
        return SCL_PENDING;
    endfunction

    // Advances the bus-clear sequence by one tick and returns the line drives after it.
    function automatic bcs_pkg::tick_out_t advance_bus_clear(input bcs_pkg::tick_in_t t);
        bcs_pkg::tick_out_t r;
        scl_poll_e poll;
        r = '0;
        case (seq_phase)
            bcs_pkg::PH_IDLE: begin
                if (t.start_request) enter_phase(bcs_pkg::PH_SETTLE);
            end
            bcs_pkg::PH_SETTLE: begin
                if (half_period_elapsed()) enter_phase(bcs_pkg::PH_WAIT);
            end
            bcs_pkg::PH_WAIT: begin
                poll = poll_scl_rise(t.scl_level);
                if (poll == SCL_TIMED_OUT) begin
                    last_result = bcs_pkg::STATUS_TIMEOUT;
                    r.done_res = 1'b1;
                    enter_phase(bcs_pkg::PH_IDLE);
                end else if (poll == SCL_HIGH) begin
                    pulses_given = '0;
                    if (!t.sda_level && max_pulses_cfg != 4'd0) enter_phase(bcs_pkg::PH_PLOW);
                    else enter_phase(bcs_pkg::PH_SCLLOW);
                end
            end
            bcs_pkg::PH_PLOW: begin
                if (half_period_elapsed()) enter_phase(bcs_pkg::PH_PWAIT);
            end
            bcs_pkg::PH_PWAIT: begin
                poll = poll_scl_rise(t.scl_level);
                if (poll == SCL_TIMED_OUT) begin
                    last_result = bcs_pkg::STATUS_TIMEOUT;
                    r.done_res = 1'b1;
                    enter_phase(bcs_pkg::PH_IDLE);
                end else if (poll == SCL_HIGH) begin
                    enter_phase(bcs_pkg::PH_PHIGH);
                end
            end
            bcs_pkg::PH_PHIGH: begin
                if (half_period_elapsed()) begin
                    pulses_given = pulses_given + 4'd1;
                    if (t.sda_level || pulses_given >= max_pulses_cfg) begin
                        enter_phase(bcs_pkg::PH_SCLLOW);
                    end else begin
                        enter_phase(bcs_pkg::PH_PLOW);
                    end
                end
            end
            bcs_pkg::PH_SCLLOW: begin
                if (half_period_elapsed()) enter_phase(bcs_pkg::PH_SDALOW);
            end
            bcs_pkg::PH_SDALOW: begin
                if (half_period_elapsed()) enter_phase(bcs_pkg::PH_SWAIT);
            end
            bcs_pkg::PH_SWAIT: begin
                // A timeout here still moves on with the stop condition.
                if (poll_scl_rise(t.scl_level) != SCL_PENDING) enter_phase(bcs_pkg::PH_SHOLD);
            end
            bcs_pkg::PH_SHOLD: begin
                if (half_period_elapsed()) enter_phase(bcs_pkg::PH_SEND);
            end
            bcs_pkg::PH_SEND: begin
                if (half_period_elapsed()) begin
                    last_result = (t.scl_level && t.sda_level) ? bcs_pkg::STATUS_OK
                                                               : bcs_pkg::STATUS_LINE_LOW;
                    r.done_res = 1'b1;
                    enter_phase(bcs_pkg::PH_IDLE);
                end
            end
            default: enter_phase(bcs_pkg::PH_IDLE);
        endcase

        // Drives follow the phase reached on this tick.
        case (seq_phase)
            bcs_pkg::PH_PLOW, bcs_pkg::PH_SCLLOW: r.scl_pull_low = 1'b1;
            bcs_pkg::PH_SDALOW: begin
                r.scl_pull_low = 1'b1;
                r.sda_pull_low = 1'b1;
            end
            bcs_pkg::PH_SWAIT, bcs_pkg::PH_SHOLD: r.sda_pull_low = 1'b1;
            default: ;
        endcase
        r.busy_res = (seq_phase != bcs_pkg::PH_IDLE);
        r.status   = last_result;
        return r;
    endfunction

    function automatic int field_differs(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Offers one tick and records what it should produce once the transfer happens.
    task automatic send_tick(input bcs_pkg::tick_in_t stim, input bit typed,
                             input bcs_pkg::tick_out_t want);
        int gap;
        bcs_pkg::tick_out_t predicted;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, stim};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_bus_clear(stim);
        pending_drive_q.push_back(typed ? want : predicted);
    endtask

    // Register writes wait until every result of the earlier ticks has come back.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_drive_q.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bcs_pkg::CFG_HALF_PERIOD: half_period_cfg = val[7:0];
            bcs_pkg::CFG_SCL_WAIT:    wait_limit_cfg  = val;
            bcs_pkg::CFG_MAX_PULSES:  max_pulses_cfg  = val[3:0];
            default: ;
        endcase
    endtask

    // Result side: checks every transfer and draws its own stalls.
    initial begin : drain_results
        bcs_pkg::tick_out_t want;
        bcs_pkg::tick_out_t got;
        int stall;
        int results_seen;
        stall = 0;
        results_seen = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                results_seen++;
                got = m_tdata[5:0];
                if (pending_drive_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_drive_q.pop_front();
                    error_count += field_differs("scl_pull_low", 8'(want.scl_pull_low),
                                                 8'(got.scl_pull_low));
                    error_count += field_differs("sda_pull_low", 8'(want.sda_pull_low),
                                                 8'(got.sda_pull_low));
                    error_count += field_differs("busy_res", 8'(want.busy_res),
                                                 8'(got.busy_res));
                    error_count += field_differs("done_res", 8'(want.done_res),
                                                 8'(got.done_res));
                    error_count += field_differs("status", 8'(want.status), 8'(got.status));
                    error_count += field_differs("padding", 8'd0, 8'(m_tdata[7:6]));
                end
                stall = draw_gap();
                // One long hold-off so the block fills up and stalls its input.
                if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases with different register settings.
    initial begin : run_stimulus
        bcs_pkg::tick_in_t stim;
        int                p_start;
        int                p_scl;
        int                p_sda;
        logic [7:0]        hp;
        logic [15:0]       lim;
        logic [3:0]        mp;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = bcs_pkg::CFG_HALF_PERIOD;
        cfg_data  = '0;

        seq_phase       = bcs_pkg::PH_IDLE;
        seq_ticks       = '0;
        pulses_given    = '0;
        last_result     = bcs_pkg::STATUS_OK;
        half_period_cfg = bcs_pkg::HALF_PERIOD_RESET;
        wait_limit_cfg  = bcs_pkg::SCL_WAIT_RESET;
        max_pulses_cfg  = bcs_pkg::MAX_PULSES_RESET;
        p_start = 0;
        p_scl   = 0;
        p_sda   = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                stim.start_request = dir_rows[i].start;
                stim.scl_level     = dir_rows[i].scl;
                stim.sda_level     = dir_rows[i].sda;
                send_tick(stim, dir_rows[i].typed, dir_rows[i].want);
            end
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin hp = 8'd1;   lim = 16'd0;     mp = 4'd1;  end
                1: begin hp = 8'd0;   lim = 16'd3;     mp = 4'd0;  end
                2: begin hp = 8'd2;   lim = 16'd6;     mp = 4'd15; end
                3: begin hp = 8'd255; lim = 16'd65535; mp = 4'd15; end
                4: begin hp = 8'd3;   lim = 16'd2;     mp = 4'd9;  end
                5: begin
                    hp  = bcs_pkg::HALF_PERIOD_RESET;
                    lim = bcs_pkg::SCL_WAIT_RESET;
                    mp  = bcs_pkg::MAX_PULSES_RESET;
                end
                default: begin
                    hp  = 8'($urandom_range(0, 4));
                    lim = 16'($urandom_range(0, 10));
                    mp  = 4'($urandom_range(0, 15));
                end
            endcase
            write_register(bcs_pkg::CFG_HALF_PERIOD, {8'd0, hp});
            write_register(bcs_pkg::CFG_SCL_WAIT, lim);
            write_register(bcs_pkg::CFG_MAX_PULSES, {12'd0, mp});
            quiet_mode = (ph % 3 == 2);

            for (int n = 0; n < PHASE_TICKS; n++) begin
                // Each episode models a bus condition: free, stretched, stuck SDA, dead SCL.
                if (n % EPISODE_TICKS == 0) begin
                    p_start = start_bias[$urandom_range(0, 2)];
                    p_scl   = scl_bias[$urandom_range(0, 3)];
                    p_sda   = sda_bias[$urandom_range(0, 3)];
                end
                stim.start_request = ($urandom_range(0, 99) < p_start);
                stim.scl_level     = ($urandom_range(0, 99) < p_scl);
                stim.sda_level     = ($urandom_range(0, 99) < p_sda);
                send_tick(stim, 1'b0, QUIET_IDLE);
            end
            s_tvalid <= 1'b0;
        end

        // Let every result drain, then watch on for strays before finishing.
        do @(posedge aclk); while (pending_drive_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bcs_pkg.sv
src/bcs_cfg.sv
src/bcs_step.sv
src/i2c_bus_clear_sequencer.sv
tb/sv/i2c_bus_clear_sequencer_tb.sv
